// ===== sv/blos_pkg.sv =====
// Shared types and constants for the line-of-sight stepper.
package blos_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int GUARD_BITS = COORD_BITS + 2;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_QUERY   = 2'd0,
    ST_VISIBLE = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

  typedef struct packed {
    logic                  func;
    logic [COORD_BITS-1:0] from_x;
    logic [COORD_BITS-1:0] from_y;
    logic [COORD_BITS-1:0] to_x;
    logic [COORD_BITS-1:0] to_y;
    logic [COORD_BITS-1:0] range_limit;
    logic                  cell_clear;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    status_t               status;
    logic                  last;
  } out_item_t;

endpackage

// ===== sv/bresenham_line_of_sight_stepper.sv =====
// Top level of the line-of-sight stepper: input register, walk logic, result register.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_item  (blos_pkg::in_item_t)
//   out     | output    | out_valid/out_stall| out_item (blos_pkg::out_item_t)
//
// Every item gives exactly one result, which passes from the input register
// through the walk logic into the result register once the output is free.
// One item can be accepted in every cycle while in_stall is low; the walk state updates as each item fires.
// A stalled output holds its result; the input register keeps taking an item
// until it too is full, then in_stall rises.
// Reset clears both valid flags and ends any walk in progress.
module bresenham_line_of_sight_stepper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  blos_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output blos_pkg::out_item_t out_item
);

  blos_pkg::in_item_t  in_r;
  logic                in_v_r;
  blos_pkg::out_item_t out_r;
  logic                out_v_r;
  blos_pkg::out_item_t res;
  logic                fire;

  assign fire     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !fire;

  blos_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_item;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

// ===== sv/blos_core.sv =====
// Walk state and the combinational start/step logic of the line walk.
module blos_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  blos_pkg::in_item_t  item,
  output blos_pkg::out_item_t res
);

  localparam int C = blos_pkg::COORD_BITS;
  localparam int E = blos_pkg::ERR_BITS;
  localparam int G = blos_pkg::GUARD_BITS;

  logic                active_r, active_nxt;
  logic [C-1:0]        cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [C-1:0]        tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [C-1:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic                xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic signed [E-1:0] err_r, err_nxt;
  logic [G-1:0]        guard_r, guard_nxt;

  logic                is_start, fx_lt, fy_lt, same, oor;
  logic [C-1:0]        adx, ady, cheb;
  logic [C-1:0]        bx, by, bdx, bdy, btx, bty, nx, ny;
  logic                bxneg, byneg, mx, my, hit;
  logic signed [E-1:0] berr, start_err;
  logic signed [E:0]   e2, pdx, ndy, err_w;

  always_comb begin
    is_start  = (item.func == blos_pkg::FUNC_START);
    fx_lt     = item.from_x < item.to_x;
    fy_lt     = item.from_y < item.to_y;
    adx       = fx_lt ? item.to_x - item.from_x : item.from_x - item.to_x;
    ady       = fy_lt ? item.to_y - item.from_y : item.from_y - item.to_y;
    cheb      = (adx > ady) ? adx : ady;
    same      = (item.from_x == item.to_x) && (item.from_y == item.to_y);
    oor       = cheb > item.range_limit;
    start_err = signed'({2'b00, adx}) - signed'({2'b00, ady});

    // A start walks from the new source; a step walks from the stored cell.
    bx    = is_start ? item.from_x : cur_x_r;
    by    = is_start ? item.from_y : cur_y_r;
    bdx   = is_start ? adx : dx_r;
    bdy   = is_start ? ady : dy_r;
    btx   = is_start ? item.to_x : tgt_x_r;
    bty   = is_start ? item.to_y : tgt_y_r;
    bxneg = is_start ? !fx_lt : xneg_r;
    byneg = is_start ? !fy_lt : yneg_r;
    berr  = is_start ? start_err : err_r;

    e2    = {berr, 1'b0};
    pdx   = signed'({3'b000, bdx});
    ndy   = -signed'({3'b000, bdy});
    mx    = e2 >= ndy;
    my    = e2 <= pdx;
    err_w = signed'({berr[E-1], berr}) + (mx ? ndy : '0) + (my ? pdx : '0);
    nx    = mx ? (bxneg ? bx - C'(1) : bx + C'(1)) : bx;
    ny    = my ? (byneg ? by - C'(1) : by + C'(1)) : by;
    hit   = (nx == btx) && (ny == bty);

    active_nxt = active_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    xneg_nxt   = xneg_r;
    yneg_nxt   = yneg_r;
    err_nxt    = err_r;
    guard_nxt  = guard_r;

    res.point_x = nx;
    res.point_y = ny;
    res.status  = hit ? blos_pkg::ST_VISIBLE : blos_pkg::ST_QUERY;
    res.last    = hit;

    if (is_start) begin
      if (same || oor) begin
        active_nxt  = 1'b0;
        res.point_x = item.from_x;
        res.point_y = item.from_y;
        res.status  = same ? blos_pkg::ST_VISIBLE : blos_pkg::ST_BLOCKED;
        res.last    = 1'b1;
      end else begin
        active_nxt = !hit;
        cur_x_nxt  = nx;
        cur_y_nxt  = ny;
        tgt_x_nxt  = item.to_x;
        tgt_y_nxt  = item.to_y;
        dx_nxt     = adx;
        dy_nxt     = ady;
        xneg_nxt   = !fx_lt;
        yneg_nxt   = !fy_lt;
        err_nxt    = err_w[E-1:0];
        guard_nxt  = G'(adx) + G'(ady) + G'(2);
      end
    end else if (!active_r) begin
      res.point_x = '0;
      res.point_y = '0;
      res.status  = blos_pkg::ST_IDLE;
      res.last    = 1'b0;
    end else if (!item.cell_clear || guard_r == '0) begin
      // Blocked answer, or the guard has run out on a clear answer.
      active_nxt  = 1'b0;
      res.point_x = cur_x_r;
      res.point_y = cur_y_r;
      res.status  = item.cell_clear ? blos_pkg::ST_VISIBLE : blos_pkg::ST_BLOCKED;
      res.last    = 1'b1;
    end else begin
      active_nxt = !hit;
      cur_x_nxt  = nx;
      cur_y_nxt  = ny;
      err_nxt    = err_w[E-1:0];
      guard_nxt  = guard_r - G'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (fire) begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      tgt_x_r <= tgt_x_nxt;
      tgt_y_r <= tgt_y_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      xneg_r  <= xneg_nxt;
      yneg_r  <= yneg_nxt;
      err_r   <= err_nxt;
      guard_r <= guard_nxt;
    end
  end

endmodule

// ===== sv/blos_checker.sv =====
// Port-level checks for the line-of-sight stepper, bound to the top level.
module blos_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input blos_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input blos_pkg::out_item_t out_item
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // The input side only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A walk ends exactly with a verdict.
  a_last_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last == (out_item.status == blos_pkg::ST_VISIBLE ||
                                     out_item.status == blos_pkg::ST_BLOCKED)))
    else $error("last flag does not match status");

  // An idle report carries the origin.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == blos_pkg::ST_IDLE |->
      out_item.point_x == '0 && out_item.point_y == '0)
    else $error("idle report with non-zero point");

  // A result appears only after an item has been taken.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid, 2) || $past(in_stall, 1))
    else $error("result without an accepted item");

endmodule

bind bresenham_line_of_sight_stepper blos_checker u_blos_checker (.*);
